FILE: sv/jrdm_pkg.sv
package jrdm_pkg;

  localparam int unsigned IR_LENGTH = 5;
  localparam logic [4:0] IR_IDCODE = 5'd1;
  localparam logic [4:0] IR_DTMCS = 5'd16;
  localparam logic [4:0] IR_DMI = 5'd17;

  localparam logic [3:0] RETRY_RESET = 4'd8;
  localparam logic [4:0] IDLE_CAP_RESET = 5'd16;

  localparam logic CFG_RETRY_LIMIT = 1'b0;
  localparam logic CFG_IDLE_CAP = 1'b1;

  // operation codes
  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_TAP_RESET = 3'd1;
  localparam logic [2:0] OP_IDCODE = 3'd2;
  localparam logic [2:0] OP_DTMCS = 3'd3;
  localparam logic [2:0] OP_DMI_READ = 3'd4;
  localparam logic [2:0] OP_DMI_WRITE = 3'd5;
  localparam logic [2:0] OP_DMI_RESET = 3'd6;

  // status codes
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FAILED = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;
  localparam logic [1:0] ST_REJECTED = 2'd3;

  // dmi answer codes
  localparam logic [1:0] RESP_OK = 2'd0;
  localparam logic [1:0] RESP_BUSY = 2'd3;

  // scan steps within a command
  localparam logic [2:0] STEP_IR = 3'd0;
  localparam logic [2:0] STEP_DR = 3'd1;
  localparam logic [2:0] STEP_NOP = 3'd2;
  localparam logic [2:0] STEP_RST_IR = 3'd3;
  localparam logic [2:0] STEP_RST_DR = 3'd4;

  // tap states
  typedef enum logic [3:0] {
    TS_RESET, TS_IDLE, TS_SEL_DR, TS_CAP_DR, TS_SH_DR, TS_EX1_DR, TS_PAU_DR, TS_EX2_DR,
    TS_UPD_DR, TS_SEL_IR, TS_CAP_IR, TS_SH_IR, TS_EX1_IR, TS_PAU_IR, TS_EX2_IR, TS_UPD_IR
  } tap_t;

  typedef enum logic [2:0] {
    PH_NONE, PH_NAVRST, PH_NAVZERO, PH_HEADER, PH_SHIFT, PH_EXIT, PH_UPDATE, PH_RUNIDLE
  } phase_t;

  typedef struct packed {
    tap_t        tap;
    logic [5:0]  abits;
    logic [4:0]  idle_cnt;
    logic        tvalid;
    phase_t      phase;
    logic [6:0]  bidx;
    logic [63:0] sout;
    logic [33:0] sin;
    logic [3:0]  attempts;
    logic [4:0]  idle_rem;
    logic [2:0]  cmd;
    logic [29:0] addr;
    logic [31:0] data;
    logic [2:0]  step;
    logic [1:0]  pend;
  } state_t;

  typedef struct packed {
    logic        clock_pulse;
    logic        tms;
    logic        tdi;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  status;
    logic [31:0] read_data;
  } result_t;

  function automatic tap_t tap_advance(tap_t s, logic t);
    tap_t n;
    n = TS_RESET;
    unique case (s)
      TS_RESET:  n = t ? TS_RESET : TS_IDLE;
      TS_IDLE:   n = t ? TS_SEL_DR : TS_IDLE;
      TS_SEL_DR: n = t ? TS_SEL_IR : TS_CAP_DR;
      TS_CAP_DR: n = t ? TS_EX1_DR : TS_SH_DR;
      TS_SH_DR:  n = t ? TS_EX1_DR : TS_SH_DR;
      TS_EX1_DR: n = t ? TS_UPD_DR : TS_PAU_DR;
      TS_PAU_DR: n = t ? TS_EX2_DR : TS_PAU_DR;
      TS_EX2_DR: n = t ? TS_UPD_DR : TS_SH_DR;
      TS_UPD_DR: n = t ? TS_SEL_DR : TS_IDLE;
      TS_SEL_IR: n = t ? TS_RESET : TS_CAP_IR;
      TS_CAP_IR: n = t ? TS_EX1_IR : TS_SH_IR;
      TS_SH_IR:  n = t ? TS_EX1_IR : TS_SH_IR;
      TS_EX1_IR: n = t ? TS_UPD_IR : TS_PAU_IR;
      TS_PAU_IR: n = t ? TS_EX2_IR : TS_PAU_IR;
      TS_EX2_IR: n = t ? TS_UPD_IR : TS_SH_IR;
      TS_UPD_IR: n = t ? TS_SEL_DR : TS_IDLE;
      default:   n = TS_RESET;
    endcase
    return n;
  endfunction

endpackage

FILE: sv/jrdm_core.sv
module jrdm_core import jrdm_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          step_en,
  input  logic [3:0]    retry_limit,
  input  logic [4:0]    idle_cap,
  input  logic [2:0]    operation,
  input  logic [29:0]   address,
  input  logic [31:0]   write_data,
  input  logic          tdo_bit,
  output result_t       res
);

  state_t st;
  state_t st_next;

  function automatic logic is_dmi(state_t s);
    return (s.cmd == OP_DMI_READ) || (s.cmd == OP_DMI_WRITE);
  endfunction

  function automatic logic is_ir(state_t s);
    return (s.step == STEP_IR) || (s.step == STEP_RST_IR);
  endfunction

  function automatic logic idles(state_t s);
    return is_dmi(s) && ((s.step == STEP_DR) || (s.step == STEP_NOP));
  endfunction

  function automatic state_t begin_scan(state_t s_in, logic [2:0] stp);
    state_t s;
    logic [4:0] instr;
    s = s_in;
    s.step = stp;
    s.bidx = '0;
    s.sin = '0;
    if (is_ir(s)) begin
      if (stp == STEP_RST_IR || s.cmd == OP_DTMCS || s.cmd == OP_DMI_RESET) instr = IR_DTMCS;
      else if (s.cmd == OP_IDCODE) instr = IR_IDCODE;
      else instr = IR_DMI;
      s.sout = {59'd0, instr};
    end else if (s.cmd == OP_DMI_RESET || stp == STEP_RST_DR) begin
      s.sout = 64'd1 << 16;
    end else if (is_dmi(s) && stp == STEP_DR) begin
      s.sout = {s.addr, s.data, (s.cmd == OP_DMI_READ) ? 2'd1 : 2'd2};
    end else begin
      s.sout = '0;
    end
    if (s.tap == TS_IDLE) s.phase = PH_HEADER;
    else if (s.tap == TS_RESET) s.phase = PH_NAVZERO;
    else s.phase = PH_NAVRST;
    return s;
  endfunction

  // one tck period of work
  always_comb begin
    state_t s;
    result_t r;
    logic [6:0] len;
    logic [5:0] pos;
    logic last;
    logic t;
    logic [31:0] low;
    logic sdone;
    s = st;
    r = '0;
    sdone = 1'b0;
    t = 1'b0;
    len = '0;
    pos = '0;
    last = 1'b0;
    low = '0;

    // command start
    if (s.phase == PH_NONE && operation >= OP_TAP_RESET && operation <= OP_DMI_RESET) begin
      s.cmd = operation;
      s.addr = address;
      s.data = write_data;
      s.attempts = '0;
      s.pend = ST_OK;
      if (operation >= OP_DMI_READ && (!s.tvalid || (operation != OP_DMI_RESET &&
          {2'b00, address} >= (32'd1 << s.abits[4:0])))) begin
        r.done_res = 1'b1;
        r.status = ST_REJECTED;
      end else if (operation == OP_TAP_RESET) begin
        s.phase = PH_NAVRST;
        s.bidx = '0;
      end else begin
        s = begin_scan(s, STEP_IR);
      end
    end

    // pin sequence
    if (s.phase != PH_NONE) begin
      r.clock_pulse = 1'b1;
      unique case (s.phase)
        PH_NAVRST: begin
          t = 1'b1;
          s.tap = tap_advance(s.tap, t);
          s.bidx = s.bidx + 7'd1;
          if (s.bidx >= 7'd6) begin
            s.bidx = '0;
            if (s.cmd == OP_TAP_RESET) begin
              s.tap = TS_RESET;
              s.phase = PH_NONE;
              r.done_res = 1'b1;
            end else begin
              s.phase = PH_NAVZERO;
            end
          end
        end
        PH_NAVZERO: begin
          s.tap = tap_advance(s.tap, 1'b0);
          s.phase = PH_HEADER;
          s.bidx = '0;
        end
        PH_HEADER: begin
          t = (s.bidx == 7'd0) || (is_ir(s) && s.bidx == 7'd1);
          s.tap = tap_advance(s.tap, t);
          s.bidx = s.bidx + 7'd1;
          if (s.bidx >= (is_ir(s) ? 7'd4 : 7'd3)) begin
            s.phase = PH_SHIFT;
            s.bidx = '0;
          end
        end
        PH_SHIFT: begin
          if (is_ir(s)) len = 7'(IR_LENGTH);
          else if (idles(s)) len = 7'd34 + {1'b0, s.abits};
          else len = 7'd32;
          pos = s.bidx[5:0];
          last = ({1'b0, s.bidx} + 8'd1) >= {1'b0, len};
          t = last;
          r.tdi = s.sout[pos];
          if (pos < 6'd34 && tdo_bit) s.sin[pos] = 1'b1;
          s.tap = tap_advance(s.tap, t);
          s.bidx = s.bidx + 7'd1;
          if (last) s.phase = PH_EXIT;
        end
        PH_EXIT: begin
          t = 1'b1;
          s.tap = tap_advance(s.tap, t);
          s.phase = PH_UPDATE;
        end
        PH_UPDATE: begin
          s.tap = tap_advance(s.tap, 1'b0);
          if (idles(s) && s.idle_cnt != 5'd0) begin
            s.idle_rem = s.idle_cnt;
            s.phase = PH_RUNIDLE;
          end else begin
            sdone = 1'b1;
          end
        end
        PH_RUNIDLE: begin
          s.tap = tap_advance(s.tap, 1'b0);
          if (s.idle_rem != 5'd0) s.idle_rem = s.idle_rem - 5'd1;
          if (s.idle_rem == 5'd0) sdone = 1'b1;
        end
        default: s.phase = PH_NONE;
      endcase
      r.tms = t;
    end

    // end of a scan
    if (sdone) begin
      low = s.sin[31:0];
      if (!is_dmi(s)) begin
        if (s.step == STEP_IR) begin
          s = begin_scan(s, STEP_DR);
        end else begin
          s.phase = PH_NONE;
          r.done_res = 1'b1;
          if (s.cmd == OP_IDCODE) begin
            r.read_data = low;
          end else if (s.cmd == OP_DTMCS) begin
            s.abits = low[9:4];
            s.tvalid = (low[3:0] == 4'd1) && (low[9:4] != 6'd0) && (low[9:4] <= 6'd30);
            s.idle_cnt = {2'b00, low[14:12]};
            r.read_data = low;
          end
        end
      end else begin
        case (s.step)
          STEP_IR: s = begin_scan(s, STEP_DR);
          STEP_DR: s = begin_scan(s, STEP_NOP);
          STEP_NOP: begin
            if (s.sin[1:0] == RESP_OK) begin
              s.phase = PH_NONE;
              r.done_res = 1'b1;
              if (s.cmd == OP_DMI_READ) r.read_data = s.sin[33:2];
            end else begin
              if (s.sin[1:0] == RESP_BUSY) begin
                s.attempts = s.attempts + 4'd1;
                if (s.idle_cnt < idle_cap) s.idle_cnt = s.idle_cnt + 5'd1;
                s.pend = (s.attempts >= retry_limit) ? ST_EXHAUSTED : ST_OK;
              end else begin
                s.pend = ST_FAILED;
              end
              s = begin_scan(s, STEP_RST_IR);
            end
          end
          STEP_RST_IR: s = begin_scan(s, STEP_RST_DR);
          default: begin
            if (s.pend == ST_OK) begin
              s = begin_scan(s, STEP_IR);
            end else begin
              s.phase = PH_NONE;
              r.done_res = 1'b1;
              r.status = s.pend;
            end
          end
        endcase
      end
    end

    r.busy_res = (s.phase != PH_NONE);
    st_next = s;
    res = r;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (step_en) begin
      st <= st_next;
    end
  end

endmodule

FILE: sv/jtag_riscv_dmi_master.sv
// jtag host engine: one request per tck period, one result per request
// a result is registered at acceptance; step logic settles the whole period
// throughput: one request per cycle unless a result waits on out_ready
// reset: synchronous active-high rst puts the tap tracker in test logic reset,
// clears the transport and sequencer state and loads retry limit 8, idle cap 16
module jtag_riscv_dmi_master import jrdm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_enable,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [29:0] address,
  input  logic [31:0] write_data,
  input  logic        tdo_bit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        clock_pulse,
  output logic        tms,
  output logic        tdi,
  output logic        busy_res,
  output logic        done_res,
  output logic [1:0]  status,
  output logic [31:0] read_data
);

  logic [3:0] retry_limit;
  logic [4:0] idle_cap;
  logic       accept;
  result_t    res;
  result_t    res_q;

  assign in_ready = !out_valid || out_ready;
  assign accept = in_valid && in_ready;

  jrdm_core u_core (
    .clk(clk), .rst(rst), .step_en(accept),
    .retry_limit(retry_limit), .idle_cap(idle_cap),
    .operation(operation), .address(address), .write_data(write_data),
    .tdo_bit(tdo_bit), .res(res)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit <= RETRY_RESET;
      idle_cap <= IDLE_CAP_RESET;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        CFG_RETRY_LIMIT: retry_limit <= cfg_data[3:0];
        CFG_IDLE_CAP:    idle_cap <= cfg_data;
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) res_q <= res;
  end

  assign clock_pulse = res_q.clock_pulse;
  assign tms = res_q.tms;
  assign tdi = res_q.tdi;
  assign busy_res = res_q.busy_res;
  assign done_res = res_q.done_res;
  assign status = res_q.status;
  assign read_data = res_q.read_data;

endmodule

FILE: tb/sv/jtag_riscv_dmi_master_tb.sv
module jtag_riscv_dmi_master_tb;
  import jrdm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned ITEM_TARGET = 1950;

  logic        clk;
  logic        rst;
  logic        cfg_write_enable;
  logic        cfg_index;
  logic [4:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  operation;
  logic [29:0] address;
  logic [31:0] write_data;
  logic        tdo_bit;
  logic        out_valid;
  logic        out_ready;
  logic        clock_pulse;
  logic        tms;
  logic        tdi;
  logic        busy_res;
  logic        done_res;
  logic [1:0]  status;
  logic [31:0] read_data;

  jtag_riscv_dmi_master dut (
    .clk(clk), .rst(rst),
    .cfg_write_enable(cfg_write_enable), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .address(address), .write_data(write_data), .tdo_bit(tdo_bit),
    .out_valid(out_valid), .out_ready(out_ready),
    .clock_pulse(clock_pulse), .tms(tms), .tdi(tdi), .busy_res(busy_res),
    .done_res(done_res), .status(status), .read_data(read_data)
  );

  // tap next-state tables, indexed by state for tms low and tms high
  localparam logic [3:0] TAP_TMS0 [16] = '{1, 1, 3, 4, 4, 6, 6, 4, 1, 10, 11, 11, 13, 13, 11, 1};
  localparam logic [3:0] TAP_TMS1 [16] = '{0, 2, 9, 5, 5, 8, 7, 8, 2, 0, 12, 12, 15, 14, 15, 2};

  // host engine mirror
  tap_t        m_tap;
  logic [5:0]  m_abits;
  logic [4:0]  m_idle;
  logic        m_transport_ok;
  phase_t      m_phase;
  int unsigned m_bit;
  logic [63:0] m_out_bits;
  logic [63:0] m_in_bits;
  logic [3:0]  m_attempts;
  logic [4:0]  m_idle_left;
  logic [2:0]  m_cmd;
  logic [29:0] m_addr;
  logic [31:0] m_data;
  logic [2:0]  m_step;
  logic [1:0]  m_pending;
  logic [3:0]  m_retry_limit;
  logic [4:0]  m_idle_cap;
  result_t     m_res;

  // target answer shaping
  logic [63:0] answer_word;
  logic [3:0]  want_version;
  logic [5:0]  want_abits;
  logic [2:0]  want_idle;
  int          want_answer;

  result_t     expected_results[$];
  int unsigned errors;
  int unsigned items_sent;
  int unsigned cycles;
  bit          pacing;

  // clock and cycle limit
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic bit dmi_cmd();
    return m_cmd == OP_DMI_READ || m_cmd == OP_DMI_WRITE;
  endfunction

  function automatic bit ir_scan();
    return m_step == STEP_IR || m_step == STEP_RST_IR;
  endfunction

  function automatic int unsigned scan_bits();
    if (ir_scan()) return IR_LENGTH;
    if (dmi_cmd() && (m_step == STEP_DR || m_step == STEP_NOP)) return 34 + m_abits;
    return 32;
  endfunction

  function automatic void start_scan(logic [2:0] s);
    logic [4:0] instr;
    m_step = s;
    m_bit = 0;
    m_in_bits = '0;
    if (ir_scan()) begin
      if (s == STEP_RST_IR || m_cmd == OP_DTMCS || m_cmd == OP_DMI_RESET) instr = IR_DTMCS;
      else if (m_cmd == OP_IDCODE) instr = IR_IDCODE;
      else instr = IR_DMI;
      m_out_bits = {59'd0, instr};
    end else if (m_cmd == OP_DMI_RESET || s == STEP_RST_DR) begin
      m_out_bits = 64'd1 << 16;
    end else if (dmi_cmd() && s == STEP_DR) begin
      m_out_bits = {m_addr, m_data, (m_cmd == OP_DMI_READ) ? 2'd1 : 2'd2};
    end else begin
      m_out_bits = '0;
    end
    if (m_tap == TS_IDLE) m_phase = PH_HEADER;
    else if (m_tap == TS_RESET) m_phase = PH_NAVZERO;
    else m_phase = PH_NAVRST;
  endfunction

  function automatic void end_command(logic [1:0] st, logic [31:0] d);
    m_phase = PH_NONE;
    m_res.done_res = 1'b1;
    m_res.status = st;
    m_res.read_data = d;
  endfunction

  // what follows a completed scan
  function automatic void scan_complete();
    logic [31:0] low;
    low = m_in_bits[31:0];
    if (!dmi_cmd()) begin
      if (m_step == STEP_IR) start_scan(STEP_DR);
      else if (m_cmd == OP_IDCODE) end_command(ST_OK, low);
      else if (m_cmd == OP_DTMCS) begin
        m_abits = low[9:4];
        m_transport_ok = low[3:0] == 4'd1 && m_abits > 0 && m_abits <= 30;
        m_idle = {2'b00, low[14:12]};
        end_command(ST_OK, low);
      end else end_command(ST_OK, '0);
      return;
    end
    case (m_step)
      STEP_IR: start_scan(STEP_DR);
      STEP_DR: start_scan(STEP_NOP);
      STEP_NOP: begin
        if (m_in_bits[1:0] == RESP_OK) begin
          end_command(ST_OK, (m_cmd == OP_DMI_READ) ? m_in_bits[33:2] : 32'd0);
          return;
        end
        if (m_in_bits[1:0] == RESP_BUSY) begin
          m_attempts = m_attempts + 4'd1;
          if (m_idle < m_idle_cap) m_idle = m_idle + 5'd1;
          m_pending = (m_attempts >= m_retry_limit) ? ST_EXHAUSTED : ST_OK;
        end else begin
          m_pending = ST_FAILED;
        end
        start_scan(STEP_RST_IR);
      end
      STEP_RST_IR: start_scan(STEP_RST_DR);
      default: begin
        if (m_pending == ST_OK) start_scan(STEP_IR);
        else end_command(m_pending, '0);
      end
    endcase
  endfunction

  function automatic void pulse(logic t, logic d);
    m_res.clock_pulse = 1'b1;
    m_res.tms = t;
    m_res.tdi = d;
    m_tap = tap_t'(t ? TAP_TMS1[m_tap] : TAP_TMS0[m_tap]);
  endfunction

  // one tck period of the sequencer
  function automatic void tck_period(logic tdo);
    bit ir, last;
    logic t;
    ir = ir_scan();
    case (m_phase)
      PH_NAVRST: begin
        pulse(1'b1, 1'b0);
        m_bit++;
        if (m_bit >= 6) begin
          m_bit = 0;
          if (m_cmd == OP_TAP_RESET) begin
            m_tap = TS_RESET;
            end_command(ST_OK, '0);
          end else m_phase = PH_NAVZERO;
        end
      end
      PH_NAVZERO: begin
        pulse(1'b0, 1'b0);
        m_phase = PH_HEADER;
        m_bit = 0;
      end
      PH_HEADER: begin
        t = (m_bit == 0 || (ir && m_bit == 1));
        pulse(t, 1'b0);
        m_bit++;
        if (m_bit >= (ir ? 4 : 3)) begin
          m_phase = PH_SHIFT;
          m_bit = 0;
        end
      end
      PH_SHIFT: begin
        last = m_bit + 1 >= scan_bits();
        pulse(last, m_out_bits[m_bit[5:0]]);
        m_in_bits[m_bit[5:0]] = tdo;
        m_bit = (m_bit + 1) & 7'h7f;
        if (last) m_phase = PH_EXIT;
      end
      PH_EXIT: begin
        pulse(1'b1, 1'b0);
        m_phase = PH_UPDATE;
      end
      PH_UPDATE: begin
        pulse(1'b0, 1'b0);
        if (dmi_cmd() && (m_step == STEP_DR || m_step == STEP_NOP) && m_idle > 0) begin
          m_idle_left = m_idle;
          m_phase = PH_RUNIDLE;
        end else scan_complete();
      end
      PH_RUNIDLE: begin
        pulse(1'b0, 1'b0);
        if (m_idle_left > 0) m_idle_left--;
        if (m_idle_left == 0) scan_complete();
      end
      default: m_phase = PH_NONE;
    endcase
  endfunction

  function automatic result_t predict_period(logic [2:0] op, logic [29:0] a, logic [31:0] d,
                                             logic tdo);
    m_res = '0;
    if (m_phase == PH_NONE && op >= OP_TAP_RESET && op <= OP_DMI_RESET) begin
      m_cmd = op;
      m_addr = a;
      m_data = d;
      m_attempts = '0;
      m_pending = ST_OK;
      if (op >= OP_DMI_READ && (!m_transport_ok ||
          (op != OP_DMI_RESET && {2'b00, a} >= (32'd1 << m_abits[4:0]))))
        end_command(ST_REJECTED, '0);
      else if (op == OP_TAP_RESET) begin
        m_phase = PH_NAVRST;
        m_bit = 0;
      end else start_scan(STEP_IR);
    end
    if (m_phase != PH_NONE) tck_period(tdo);
    m_res.busy_res = m_phase != PH_NONE;
    return m_res;
  endfunction

  // target side: answer word for the scan that is starting
  function automatic logic [63:0] target_answer();
    logic [63:0] w;
    int r;
    w = {$urandom, $urandom};
    if (ir_scan()) return w;
    if (m_cmd == OP_DTMCS && m_step == STEP_DR) begin
      w[3:0] = want_version;
      w[9:4] = want_abits;
      w[14:12] = want_idle;
    end else if (dmi_cmd() && m_step == STEP_NOP) begin
      if (want_answer >= 0) w[1:0] = want_answer[1:0];
      else begin
        r = $urandom_range(0, 99);
        w[1:0] = (r < 55) ? RESP_OK : (r < 80) ? RESP_BUSY : (r < 92) ? 2'd1 : 2'd2;
      end
    end
    return w;
  endfunction

  function automatic logic next_tdo();
    if (m_phase != PH_SHIFT) return $urandom_range(0, 1);
    if (m_bit == 0) answer_word = target_answer();
    return answer_word[m_bit[5:0]];
  endfunction

  task automatic report(string what, logic [31:0] want, logic [31:0] got);
    $display("mismatch %s: expected %h got %h at cycle %0d", what, want, got, cycles);
    errors++;
  endtask

  // send one request and record what it should produce
  task automatic send_request(logic [2:0] op, logic [29:0] a, logic [31:0] d);
    int gap;
    logic t;
    bit ok;
    gap = pacing ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    t = next_tdo();
    operation <= op;
    address <= a;
    write_data <= d;
    tdo_bit <= t;
    in_valid <= 1'b1;
    do begin
      @(negedge clk);
      ok = in_ready;
      @(posedge clk);
    end while (!ok);
    items_sent++;
    expected_results.push_back(predict_period(op, a, d, t));
  endtask

  // issue a command and keep the tck running until it is over, with noise on the ops
  task automatic run_command(logic [2:0] op, logic [29:0] a, logic [31:0] d);
    send_request(op, a, d);
    while (m_phase != PH_NONE)
      send_request(3'($urandom_range(0, 7)), 30'($urandom), $urandom);
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(logic idx, logic [4:0] value);
    wait_quiet();
    cfg_write_enable <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    if (idx == CFG_RETRY_LIMIT) m_retry_limit = value[3:0];
    else m_idle_cap = value;
  endtask

  task automatic set_target(logic [3:0] ver, logic [5:0] ab, logic [2:0] idl);
    want_version = ver;
    want_abits = ab;
    want_idle = idl;
  endtask

  function automatic logic [29:0] dmi_address();
    if ($urandom_range(0, 9) == 0) return 30'($urandom);
    return 30'($urandom) & 30'((32'd1 << m_abits[4:0]) - 1);
  endfunction

  // result checker
  initial begin
    result_t want;
    result_t got;
    int stall;
    bit hit;
    out_ready <= 1'b0;
    @(negedge rst);
    forever begin
      stall = pacing ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        hit = out_valid;
        got = '{clock_pulse, tms, tdi, busy_res, done_res, status, read_data};
        @(posedge clk);
      end while (!hit);
      if (expected_results.size() == 0) begin
        report("unexpected result", '0, '1);
      end else begin
        want = expected_results.pop_front();
        if (got.clock_pulse !== want.clock_pulse)
          report("clock_pulse", want.clock_pulse, got.clock_pulse);
        if (got.tms !== want.tms) report("tms", want.tms, got.tms);
        if (got.tdi !== want.tdi) report("tdi", want.tdi, got.tdi);
        if (got.busy_res !== want.busy_res) report("busy_res", want.busy_res, got.busy_res);
        if (got.done_res !== want.done_res) report("done_res", want.done_res, got.done_res);
        if (got.status !== want.status) report("status", want.status, got.status);
        if (got.read_data !== want.read_data) report("read_data", want.read_data, got.read_data);
      end
    end
  end

  // commands before any transport is known, op seven and idle periods
  task automatic test_no_transport();
    run_command(OP_DMI_READ, '0, '0);
    run_command(OP_DMI_RESET, '0, '0);
    run_command(3'd7, '1, '1);
    run_command(OP_NONE, '0, '0);
    run_command(OP_IDCODE, '0, '0);
  endtask

  task automatic test_tap_reset();
    run_command(OP_TAP_RESET, '0, '0);
    run_command(OP_IDCODE, '1, '1);
    run_command(OP_TAP_RESET, '0, '0);
  endtask

  // dtmcs decode, bad transports and address range edges
  task automatic test_dtmcs();
    set_target(4'd0, 6'd7, 3'd0);
    run_command(OP_DTMCS, '0, '0);
    run_command(OP_DMI_RESET, '0, '0);
    set_target(4'd1, 6'd0, 3'd0);
    run_command(OP_DTMCS, '0, '0);
    set_target(4'd1, 6'd31, 3'd0);
    run_command(OP_DTMCS, '0, '0);
    run_command(OP_DMI_WRITE, '0, '0);
    set_target(4'd1, 6'd30, 3'd7);
    run_command(OP_DTMCS, '0, '0);
    want_answer = RESP_OK;
    run_command(OP_DMI_WRITE, '1, '1);
    run_command(OP_DMI_READ, '0, '0);
    set_target(4'd1, 6'd1, 3'd0);
    run_command(OP_DTMCS, '0, '0);
    run_command(OP_DMI_READ, 30'd2, '0);
    run_command(OP_DMI_READ, 30'd1, '0);
    run_command(OP_DMI_RESET, '1, '1);
  endtask

  // failed, code two and busy until the retries run out
  task automatic test_dmi_answers();
    want_answer = 1;
    run_command(OP_DMI_READ, 30'd1, '1);
    want_answer = 2;
    run_command(OP_DMI_WRITE, 30'd0, '1);
    write_config(CFG_RETRY_LIMIT, 5'd2);
    want_answer = RESP_BUSY;
    run_command(OP_DMI_READ, 30'd1, '0);
    want_answer = -1;
  endtask

  task automatic random_command();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      if ($urandom_range(0, 99) < 85)
        set_target(4'd1, ($urandom_range(0, 9) == 0) ? 6'd30 : 6'($urandom_range(1, 8)),
                   3'($urandom_range(0, 2)));
      else set_target(4'($urandom), 6'($urandom), 3'($urandom));
      run_command(OP_DTMCS, 30'($urandom), $urandom);
    end else if (r < 11) run_command(OP_TAP_RESET, 30'($urandom), $urandom);
    else if (r < 15) run_command(OP_IDCODE, 30'($urandom), $urandom);
    else if (r < 19) run_command(OP_DMI_RESET, 30'($urandom), $urandom);
    else if (r < 22) run_command(3'($urandom_range(0, 7)), 30'($urandom), $urandom);
    else if (r < 61) run_command(OP_DMI_READ, dmi_address(), $urandom);
    else run_command(OP_DMI_WRITE, dmi_address(), $urandom);
  endtask

  // register settings, extremes included, each with a run of random commands
  task automatic test_random();
    logic [3:0] limits [5] = '{4'd1, 4'd15, 4'd0, 4'd3, 4'd8};
    logic [4:0] caps [5] = '{5'd0, 5'd31, 5'd2, 5'd5, 5'd16};
    int k;
    int unsigned stop;
    int unsigned budget;
    for (k = 0; k < 5; k++) begin
      write_config(CFG_RETRY_LIMIT, {1'b0, limits[k]});
      write_config(CFG_IDLE_CAP, caps[k]);
      budget = (items_sent < ITEM_TARGET) ?
               (ITEM_TARGET - items_sent) / unsigned'(5 - k) : 0;
      stop = items_sent + budget;
      set_target(4'd1, 6'($urandom_range(1, 6)), 3'($urandom_range(0, 2)));
      run_command(OP_DTMCS, '0, '0);
      while (items_sent < stop) begin
        if ($urandom_range(0, 39) == 0) pacing = !pacing;
        random_command();
      end
    end
  endtask

  // stimulus sequence
  initial begin
    cycles = 0;
    errors = 0;
    items_sent = 0;
    pacing = 1'b1;
    want_answer = -1;
    answer_word = '0;
    set_target(4'd1, 6'd4, 3'd1);
    m_tap = TS_RESET;
    m_abits = '0;
    m_idle = '0;
    m_transport_ok = 1'b0;
    m_phase = PH_NONE;
    m_bit = 0;
    m_out_bits = '0;
    m_in_bits = '0;
    m_attempts = '0;
    m_idle_left = '0;
    m_cmd = '0;
    m_addr = '0;
    m_data = '0;
    m_step = STEP_IR;
    m_pending = ST_OK;
    m_retry_limit = RETRY_RESET;
    m_idle_cap = IDLE_CAP_RESET;
    rst <= 1'b1;
    cfg_write_enable <= 1'b0;
    cfg_index <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    operation <= OP_NONE;
    address <= '0;
    write_data <= '0;
    tdo_bit <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_no_transport();
    test_tap_reset();
    test_dtmcs();
    test_dmi_answers();
    test_random();
    wait_quiet();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/jrdm_pkg.sv
sv/jrdm_core.sv
sv/jtag_riscv_dmi_master.sv
tb/sv/jtag_riscv_dmi_master_tb.sv
